// ===== rtl/rgbtile_pkg.sv =====
// Shared types, constants and helpers for the tiled RGB565 encoder.
`timescale 1ns / 1ps

package rgbtile_pkg;

  // Field widths of the input pixel request
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int CHAN_W  = 8;
  localparam int PAIR_W  = COL_W - 1;

  // Field widths of a result request
  localparam int INDEX_W = 19;
  localparam int C565_W  = 16;
  localparam int NIB_W   = 4;
  localparam int SUM_W   = CHAN_W + 1;
  localparam int BOX_W   = CHAN_W + 2;
  localparam int TILE_W  = 8;
  localparam int CFG_W   = 3;

  // Packed stream widths, padded to whole bytes
  localparam int IN_BITS  = COL_W + ROW_W + 4 * CHAN_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = INDEX_W + C565_W + NIB_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Reset value of the height register
  localparam logic [CFG_W-1:0] HEIGHT_TILES_RESET = CFG_W'(1);

  // Result kinds carried on tuser
  localparam logic SCALE_FULL = 1'b0;
  localparam logic SCALE_HALF = 1'b1;

  // Which result of the held pixel goes out next
  typedef enum logic {
    PH_FULL,
    PH_HALF
  } phase_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgba_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } pixel_t;

  // Horizontal pair sums, one 9-bit sum per channel
  typedef struct packed {
    logic [SUM_W-1:0] alpha;
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sums_t;

  // Pixel held between the input register and the result register
  typedef struct packed {
    pixel_t pix;
    sums_t  here;
    logic   above_ok;
  } stage_t;

  typedef struct packed {
    logic               scale_kind;
    logic [INDEX_W-1:0] texel_index;
    logic [C565_W-1:0]  color565;
    logic [NIB_W-1:0]   alpha_nibble;
    logic               nibble_high;
    logic               last;
  } result_t;

  // Per-channel sum of two pixels
  function automatic sums_t pack_sum(rgba_t a, rgba_t b);
    sums_t s;
    s.red   = SUM_W'(a.red)   + SUM_W'(b.red);
    s.green = SUM_W'(a.green) + SUM_W'(b.green);
    s.blue  = SUM_W'(a.blue)  + SUM_W'(b.blue);
    s.alpha = SUM_W'(a.alpha) + SUM_W'(b.alpha);
    return s;
  endfunction

endpackage

// ===== rtl/rgbtile_line_store.sv =====
// Line store of horizontal pair sums from even rows, registered read.
`timescale 1ns / 1ps

module rgbtile_line_store
  import rgbtile_pkg::*;
#(
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  sums_t                    wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output sums_t                    rd_data
);

  sums_t mem [DEPTH];

  // One write and one read port, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rgbtile_format.sv =====
// Builds the full-resolution and half-scale results of the held pixel.
`timescale 1ns / 1ps

module rgbtile_format
  import rgbtile_pkg::*;
(
  input  stage_t             stage,
  input  sums_t              above,
  input  logic [CFG_W-1:0]   height_tiles,
  output result_t            full_res,
  output result_t            half_res
);

  logic [COL_W-1:0]   x;
  logic [ROW_W-1:0]   y;
  logic [TILE_W-1:0]  tile;
  logic [11:0]        full_base;
  logic [9:0]         half_base;
  logic               half;
  sums_t              above_use;
  logic [BOX_W-1:0]   box_r;
  logic [BOX_W-1:0]   box_g;
  logic [BOX_W-1:0]   box_b;
  logic [BOX_W-1:0]   box_a;

  assign x    = stage.pix.col;
  assign y    = stage.pix.row;
  assign half = x[0] & y[0];

  // Badge tile offset: height_tiles * (x / 64) + y / 64
  assign tile = TILE_W'(height_tiles) * TILE_W'(x[COL_W-1:6]) + TILE_W'(y[ROW_W-1:6]);

  // Morton order inside 8x8 blocks, blocks in row-major order, in a 64x64 and a 32x32 tile
  assign full_base = {y[5:3], x[5:3], y[2], x[2], y[1], x[1], y[0], x[0]};
  assign half_base = {y[5:4], x[5:4], y[3], x[3], y[2], x[2], y[1], x[1]};

  // Pairs beyond the line store read as zero
  assign above_use = stage.above_ok ? above : '0;

  // 2x2 box sums
  assign box_r = BOX_W'(above_use.red)   + BOX_W'(stage.here.red);
  assign box_g = BOX_W'(above_use.green) + BOX_W'(stage.here.green);
  assign box_b = BOX_W'(above_use.blue)  + BOX_W'(stage.here.blue);
  assign box_a = BOX_W'(above_use.alpha) + BOX_W'(stage.here.alpha);

  // Full-resolution write
  always_comb begin
    full_res.scale_kind   = SCALE_FULL;
    full_res.texel_index  = {tile[6:0], full_base};
    full_res.color565     = {stage.pix.red[7:3], stage.pix.green[7:2], stage.pix.blue[7:3]};
    full_res.alpha_nibble = stage.pix.alpha[7:4];
    full_res.nibble_high  = x[0];
    full_res.last         = ~half;
  end

  // Half-scale write
  always_comb begin
    half_res.scale_kind   = SCALE_HALF;
    half_res.texel_index  = {1'b0, tile, half_base};
    half_res.color565     = {box_r[9:5], box_g[9:4], box_b[9:5]};
    half_res.alpha_nibble = box_a[9:6];
    half_res.nibble_high  = x[1];
    half_res.last         = 1'b1;
  end

endmodule

// ===== rtl/rgba8_to_tiled_rgb565_with_half_scale_top.sv =====
// Top level: RGBA8 raster pixels in, Morton-tiled RGB565 + A4 writes out.
`timescale 1ns / 1ps

// Each pixel request gives one full-resolution write into a 64x64-tiled
// buffer (tuser 0); a pixel at an odd row and odd column also gives a
// 2x2 box-averaged write into a 32x32-tiled buffer (tuser 1), and tlast
// marks the final write of a pixel. A pixel is accepted every cycle while
// it gives one write and the output is not stalled; a pixel with two
// writes holds the block until both pass the single output register. Pair
// sums of even rows are kept in a LINE_PAIRS-entry line store that is
// written and read when a pixel is accepted; it has no reset and needs no
// clearing pass. The user must write height_tiles only while the block is
// idle; the block itself does not enforce this.

module rgba8_to_tiled_rgb565_with_half_scale_top
  import rgbtile_pkg::*;
#(
  parameter int LINE_PAIRS = 384
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration: height_tiles
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  // Pixel requests
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // col, row, red_in, green_in, blue_in, alpha_in
  // Write requests
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // texel_index, color565, alpha_nibble, nibble_high
  output logic             m_axis_tuser,  // scale_kind
  output logic             m_axis_tlast   // last
);

  localparam int AW = $clog2(LINE_PAIRS);
  localparam logic [PAIR_W:0] PAIRS_LIM = (PAIR_W + 1)'(LINE_PAIRS);

  logic [CFG_W-1:0]  height_tiles;
  rgba_t             pair_left;
  pixel_t            in_pix;
  rgba_t             in_rgba;
  logic [PAIR_W-1:0] in_pair;
  logic              in_range;
  sums_t             in_sums;
  logic              accept;

  stage_t            s1;
  logic              s1_valid;
  logic              s1_valid_next;
  logic              s1_half;
  phase_t            phase;
  phase_t            phase_next;
  sums_t             above;

  result_t           full_res;
  result_t           half_res;
  result_t           res_sel;
  result_t           out_res;
  logic              out_free;
  logic              emit;
  logic              s1_done;

  // Unpack the pixel request
  assign in_pix  = pixel_t'(s_axis_tdata[IN_BITS-1:0]);
  assign in_rgba = {in_pix.alpha, in_pix.blue, in_pix.green, in_pix.red};
  assign in_pair = in_pix.col[COL_W-1:1];
  assign in_range = {1'b0, in_pair} < PAIRS_LIM;
  assign in_sums = pack_sum(pair_left, in_rgba);

  // Handshake and hold control
  assign out_free = ~m_axis_tvalid | m_axis_tready;
  assign s1_half  = s1.pix.col[0] & s1.pix.row[0];
  assign emit     = s1_valid & out_free;
  assign s1_done  = emit & (~s1_half | (phase == PH_HALF));
  assign s_axis_tready = ~s1_valid | s1_done;
  assign accept   = s_axis_tvalid & s_axis_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      height_tiles <= HEIGHT_TILES_RESET;
    end else if (cfg_we) begin
      height_tiles <= cfg_wdata;
    end
  end

  // Left pixel of the current horizontal pair
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_left <= '0;
    end else if (accept && !in_pix.col[0]) begin
      pair_left <= in_rgba;
    end
  end

  // Line store: odd columns of even rows write pair sums, every accepted pixel reads
  rgbtile_line_store #(
    .DEPTH (LINE_PAIRS)
  ) u_line (
    .clk     (clk),
    .wr_en   (accept & in_pix.col[0] & ~in_pix.row[0] & in_range),
    .wr_addr (in_pair[AW-1:0]),
    .wr_data (in_sums),
    .rd_en   (accept),
    .rd_addr (in_pair[AW-1:0]),
    .rd_data (above)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.pix      <= in_pix;
      s1.here     <= in_sums;
      s1.above_ok <= in_range;
    end
  end

  // Next state of the held pixel
  always_comb begin
    s1_valid_next = s1_valid;
    phase_next    = phase;
    if (accept) begin
      s1_valid_next = 1'b1;
      phase_next    = PH_FULL;
    end else if (s1_done) begin
      s1_valid_next = 1'b0;
    end else if (emit) begin
      phase_next    = PH_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      phase    <= PH_FULL;
    end else begin
      s1_valid <= s1_valid_next;
      phase    <= phase_next;
    end
  end

  rgbtile_format u_format (
    .stage        (s1),
    .above        (above),
    .height_tiles (height_tiles),
    .full_res     (full_res),
    .half_res     (half_res)
  );

  // Result select by phase
  always_comb begin
    case (phase)
      PH_FULL: res_sel = full_res;
      PH_HALF: res_sel = half_res;
      default: res_sel = full_res;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= res_sel;
    end
  end

  assign m_axis_tdata = OUT_W'({out_res.nibble_high, out_res.alpha_nibble,
                                out_res.color565, out_res.texel_index});
  assign m_axis_tuser = out_res.scale_kind;
  assign m_axis_tlast = out_res.last;

  // A half-scale write always closes its pixel
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == SCALE_HALF) |-> m_axis_tlast)
    else $error("half-scale write without last");

  // A full write that is not last is followed at once by its half-scale write
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tuser == SCALE_HALF))
    else $error("missing half-scale write after full write");

  // An accepted pixel is held and starts with its full write
  assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid && (phase == PH_FULL))
    else $error("accepted pixel not held in input register");

endmodule
